### rtl/core/bpc_pkg.sv
// Shared widths, register indexes and calibration word bundle for the
// barometric compensation pipeline. No dependencies.
`default_nettype none

package bpc_pkg;

    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int TEMP_W     = 19;
    localparam int PRES_W     = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 56;

    localparam int DT_W       = 25;
    localparam int MUL_W      = 41;
    localparam int SQ_DT_W    = 50;
    localparam int DEV_W      = 18;
    localparam int OFF1_W     = 35;
    localparam int SENS1_W    = 34;
    localparam int T2_W       = 19;
    localparam int SQ_W       = 36;
    localparam int A5_W       = 38;
    localparam int OFF_W      = 38;
    localparam int SENS_W     = 37;
    localparam int LO_W       = 18;
    localparam int HI_W       = SENS_W - LO_W;
    localparam int PLO_W      = RAW_W + LO_W;
    localparam int PHI_W      = RAW_W + 1 + HI_W;
    localparam int PROD_W     = PHI_W + LO_W;
    localparam int Q_W        = PROD_W - 21;
    localparam int DIFF_W     = Q_W + 1;
    localparam int P_W        = DIFF_W - 15;

    localparam int STAGES     = 8;

    localparam logic signed [TEMP_W:0] TEMP_BASE = 2000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PRESSURE_SENSITIVITY  = 3'd0,
        REG_PRESSURE_OFFSET       = 3'd1,
        REG_SENS_TEMP_COEFF       = 3'd2,
        REG_OFFSET_TEMP_COEFF     = 3'd3,
        REG_REFERENCE_TEMPERATURE = 3'd4,
        REG_TEMP_SENS_COEFF       = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sens_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temp_sens_coeff;
    } cal_t;

endpackage

`default_nettype wire

### rtl/core/bpc_cfg.sv
// Calibration word register file, written through the plain write port.
// Depends on bpc_pkg.
`default_nettype none

module bpc_cfg
    import bpc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CAL_W-1:0]      cfg_wr_data,
    output cal_t                       cal
);

    cal_t cal_reg;
    cal_t cal_next;

    always_comb begin
        cal_next = cal_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PRESSURE_SENSITIVITY:  cal_next.pressure_sensitivity  = cfg_wr_data;
                REG_PRESSURE_OFFSET:       cal_next.pressure_offset       = cfg_wr_data;
                REG_SENS_TEMP_COEFF:       cal_next.sens_temp_coeff       = cfg_wr_data;
                REG_OFFSET_TEMP_COEFF:     cal_next.offset_temp_coeff     = cfg_wr_data;
                REG_REFERENCE_TEMPERATURE: cal_next.reference_temperature = cfg_wr_data;
                REG_TEMP_SENS_COEFF:       cal_next.temp_sens_coeff       = cfg_wr_data;
                default: begin
                    cal_next = cal_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

`default_nettype wire

### rtl/core/bpc_first.sv
// First-order terms: dT, calibration products, deviation, OFF, SENS and
// the dT squared term. Three register stages. Depends on bpc_pkg.
`default_nettype none

module bpc_first
    import bpc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      adv,
    input  wire logic [RAW_W-1:0]          raw_pressure,
    input  wire logic [RAW_W-1:0]          raw_temperature,
    input  cal_t                           cal,
    output logic [RAW_W-1:0]               d1_out,
    output logic signed [DEV_W-1:0]        dev_out,
    output logic signed [OFF1_W-1:0]       off1_out,
    output logic signed [SENS1_W-1:0]      sens1_out,
    output logic [T2_W-1:0]                t2_out
);

    logic [RAW_W-1:0]           d1_s1_reg;
    logic signed [DT_W-1:0]     dt_reg;
    logic signed [DT_W-1:0]     dt_next;

    logic [RAW_W-1:0]           d1_s2_reg;
    logic signed [MUL_W-1:0]    m6_reg;
    logic signed [MUL_W-1:0]    m4_reg;
    logic signed [MUL_W-1:0]    m3_reg;
    logic signed [SQ_DT_W-1:0]  mt_reg;
    logic signed [MUL_W-1:0]    m6_next;
    logic signed [MUL_W-1:0]    m4_next;
    logic signed [MUL_W-1:0]    m3_next;
    logic signed [SQ_DT_W-1:0]  mt_next;

    logic [RAW_W-1:0]           d1_s3_reg;
    logic signed [DEV_W-1:0]    dev_reg;
    logic signed [OFF1_W-1:0]   off1_reg;
    logic signed [SENS1_W-1:0]  sens1_reg;
    logic [T2_W-1:0]            t2_reg;
    logic signed [OFF1_W-1:0]   off1_next;
    logic signed [SENS1_W-1:0]  sens1_next;

    assign dt_next = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, cal.reference_temperature, 8'b0});

    assign m6_next = MUL_W'(dt_reg) * MUL_W'($signed({1'b0, cal.temp_sens_coeff}));
    assign m4_next = MUL_W'(dt_reg) * MUL_W'($signed({1'b0, cal.offset_temp_coeff}));
    assign m3_next = MUL_W'(dt_reg) * MUL_W'($signed({1'b0, cal.sens_temp_coeff}));
    assign mt_next = SQ_DT_W'(dt_reg) * SQ_DT_W'(dt_reg);

    assign off1_next  = $signed({3'b0, cal.pressure_offset, 16'b0})
                      + $signed({m4_reg[MUL_W-1], m4_reg[MUL_W-1:7]});
    assign sens1_next = $signed({3'b0, cal.pressure_sensitivity, 15'b0})
                      + $signed({m3_reg[MUL_W-1], m3_reg[MUL_W-1:8]});

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_s1_reg <= raw_pressure;
            dt_reg    <= dt_next;

            d1_s2_reg <= d1_s1_reg;
            m6_reg    <= m6_next;
            m4_reg    <= m4_next;
            m3_reg    <= m3_next;
            mt_reg    <= mt_next;

            d1_s3_reg <= d1_s2_reg;
            dev_reg   <= m6_reg[MUL_W-1:23];
            off1_reg  <= off1_next;
            sens1_reg <= sens1_next;
            t2_reg    <= mt_reg[T2_W+30:31];
        end
    end

    assign d1_out    = d1_s3_reg;
    assign dev_out   = dev_reg;
    assign off1_out  = off1_reg;
    assign sens1_out = sens1_reg;
    assign t2_out    = t2_reg;

endmodule

`default_nettype wire

### rtl/core/bpc_cold.sv
// Cold correction: squared deviation, then temperature, OFF and SENS
// with the below-20 C terms applied. Two register stages. Depends on bpc_pkg.
`default_nettype none

module bpc_cold
    import bpc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      adv,
    input  wire logic [RAW_W-1:0]          d1_in,
    input  wire logic signed [DEV_W-1:0]   dev_in,
    input  wire logic signed [OFF1_W-1:0]  off1_in,
    input  wire logic signed [SENS1_W-1:0] sens1_in,
    input  wire logic [T2_W-1:0]           t2_in,
    output logic [RAW_W-1:0]               d1_out,
    output logic signed [TEMP_W-1:0]       temp_out,
    output logic signed [OFF_W-1:0]        off_out,
    output logic signed [SENS_W-1:0]       sens_out
);

    logic [RAW_W-1:0]           d1_s4_reg;
    logic signed [DEV_W-1:0]    dev_reg;
    logic signed [OFF1_W-1:0]   off1_reg;
    logic signed [SENS1_W-1:0]  sens1_reg;
    logic [T2_W-1:0]            t2_reg;
    logic signed [SQ_W-1:0]     sq_reg;
    logic                       cold_reg;
    logic signed [SQ_W-1:0]     sq_next;

    logic [RAW_W-1:0]           d1_s5_reg;
    logic signed [TEMP_W-1:0]   temp_reg;
    logic signed [OFF_W-1:0]    off_reg;
    logic signed [SENS_W-1:0]   sens_reg;
    logic signed [A5_W-1:0]     a5;
    logic signed [A5_W-1:0]     off_corr;
    logic signed [SENS_W-1:0]   sens_corr;
    logic signed [TEMP_W:0]     t2_corr;
    logic signed [TEMP_W:0]     temp_wide;
    logic signed [TEMP_W-1:0]   temp_next;
    logic signed [OFF_W-1:0]    off_next;
    logic signed [SENS_W-1:0]   sens_next;

    assign sq_next = SQ_W'(dev_in) * SQ_W'(dev_in);

    assign a5        = A5_W'(sq_reg) + (A5_W'(sq_reg) <<< 2);
    assign off_corr  = cold_reg ? {a5[A5_W-1], a5[A5_W-1:1]} : '0;
    assign sens_corr = cold_reg ? $signed({a5[A5_W-1], a5[A5_W-1:2]}) : '0;
    assign t2_corr   = cold_reg ? $signed({1'b0, t2_reg}) : '0;
    assign temp_wide = (TEMP_W+1)'(dev_reg) - t2_corr + TEMP_BASE;
    assign temp_next = temp_wide[TEMP_W-1:0];
    assign off_next  = OFF_W'(off1_reg) - off_corr;
    assign sens_next = SENS_W'(sens1_reg) - sens_corr;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_s4_reg <= d1_in;
            dev_reg   <= dev_in;
            off1_reg  <= off1_in;
            sens1_reg <= sens1_in;
            t2_reg    <= t2_in;
            sq_reg    <= sq_next;
            cold_reg  <= dev_in[DEV_W-1];

            d1_s5_reg <= d1_s4_reg;
            temp_reg  <= temp_next;
            off_reg   <= off_next;
            sens_reg  <= sens_next;
        end
    end

    assign d1_out   = d1_s5_reg;
    assign temp_out = temp_reg;
    assign off_out  = off_reg;
    assign sens_out = sens_reg;

`ifndef SYNTHESIS
    warm_temp_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !cold_reg |=> temp_reg == $past(dev_reg) + 2000)
        else $error("warm temperature differs from deviation plus base");

    warm_terms_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !cold_reg |=> off_reg == $past(off1_reg) && sens_reg == $past(sens1_reg))
        else $error("warm OFF or SENS altered by correction");

    cold_lowers_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && cold_reg |=> off_reg <= $past(off1_reg) && sens_reg <= $past(sens1_reg))
        else $error("cold correction raised OFF or SENS");
`endif

endmodule

`default_nettype wire

### rtl/core/bpc_press.sv
// Pressure: split D1*SENS into two partial products, recombine, then
// scale, remove OFF and clamp. Two register stages, last term unregistered.
// Depends on bpc_pkg.
`default_nettype none

module bpc_press
    import bpc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      adv,
    input  wire logic [RAW_W-1:0]          d1_in,
    input  wire logic signed [TEMP_W-1:0]  temp_in,
    input  wire logic signed [OFF_W-1:0]   off_in,
    input  wire logic signed [SENS_W-1:0]  sens_in,
    output logic signed [TEMP_W-1:0]       temp_out,
    output logic signed [PRES_W-1:0]       pres_out
);

    logic [PLO_W-1:0]           plo_reg;
    logic signed [PHI_W-1:0]    phi_reg;
    logic signed [OFF_W-1:0]    off_s6_reg;
    logic signed [TEMP_W-1:0]   temp_s6_reg;
    logic [PLO_W-1:0]           plo_next;
    logic signed [PHI_W-1:0]    phi_next;

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [OFF_W-1:0]    off_s7_reg;
    logic signed [TEMP_W-1:0]   temp_s7_reg;
    logic signed [PROD_W-1:0]   prod_next;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [P_W-1:0]      p_short;
    logic signed [PRES_W:0]     p_wide;
    logic signed [PRES_W:0]     p_max;
    logic signed [PRES_W:0]     p_min;

    assign plo_next = PLO_W'(d1_in) * PLO_W'(sens_in[LO_W-1:0]);
    assign phi_next = PHI_W'($signed({1'b0, d1_in}))
                    * PHI_W'($signed(sens_in[SENS_W-1:LO_W]));

    assign prod_next = $signed({phi_reg, {LO_W{1'b0}}})
                     + $signed({{(PROD_W-PLO_W){1'b0}}, plo_reg});

    assign diff    = DIFF_W'($signed(prod_reg[PROD_W-1:21])) - DIFF_W'(off_s7_reg);
    assign p_short = diff[DIFF_W-1:15];
    assign p_wide  = (PRES_W+1)'(p_short);
    assign p_max   = $signed({2'b00, {(PRES_W-1){1'b1}}});
    assign p_min   = $signed({2'b11, {(PRES_W-1){1'b0}}});

    always_comb begin
        if (p_wide > p_max) begin
            pres_out = p_max[PRES_W-1:0];
        end else if (p_wide < p_min) begin
            pres_out = p_min[PRES_W-1:0];
        end else begin
            pres_out = p_wide[PRES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            off_s6_reg  <= off_in;
            temp_s6_reg <= temp_in;

            prod_reg    <= prod_next;
            off_s7_reg  <= off_s6_reg;
            temp_s7_reg <= temp_s6_reg;
        end
    end

    assign temp_out = temp_s7_reg;

endmodule

`default_nettype wire

### rtl/core/baro_pressure_temp_compensation.sv
// Top level of the barometric compensation pipeline: channels, stall
// control, valid chain and output register. Depends on bpc_pkg and the
// bpc_cfg, bpc_first, bpc_cold and bpc_press modules.
//
//   channel  | ports                                | item
//   ---------+--------------------------------------+---------------------------
//   input    | s_tvalid s_tready s_tdata[47:0]      | raw_pressure, raw_temperature
//   result   | m_tvalid m_tready m_tdata[55:0]      | temperature_centi, pressure_centi
//   config   | cfg_wr_en cfg_addr[2:0] cfg_wr_data  | one calibration word per write
//
// One transaction per cycle while results are taken; an input transaction
// passes seven arithmetic stages, the first loaded at the accepting edge,
// then the output register, before it shows on m_tvalid.
// Reset clears all stage valid bits and the calibration words.
// A held result stalls the whole pipeline; s_tready is high whenever the
// output register is empty or being taken.
`default_nettype none

module baro_pressure_temp_compensation
    import bpc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  wire logic [S_TDATA_W-1:0]  s_tdata,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [18:0] temperature_centi, [50:19] pressure_centi, [55:51] zero
    output logic [M_TDATA_W-1:0]       m_tdata,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CAL_W-1:0]      cfg_wr_data
);

    cal_t                       cal;
    logic                       adv;
    logic [STAGES-2:0]          valid_reg;
    logic [STAGES-2:0]          valid_next;
    logic                       m_tvalid_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg;

    logic [RAW_W-1:0]           f_d1;
    logic signed [DEV_W-1:0]    f_dev;
    logic signed [OFF1_W-1:0]   f_off1;
    logic signed [SENS1_W-1:0]  f_sens1;
    logic [T2_W-1:0]            f_t2;

    logic [RAW_W-1:0]           c_d1;
    logic signed [TEMP_W-1:0]   c_temp;
    logic signed [OFF_W-1:0]    c_off;
    logic signed [SENS_W-1:0]   c_sens;

    logic signed [TEMP_W-1:0]   p_temp;
    logic signed [PRES_W-1:0]   p_pres;

    assign adv        = !m_tvalid_reg || m_tready;
    assign s_tready   = adv;
    assign valid_next = {valid_reg[STAGES-3:0], s_tvalid};

    bpc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cal         (cal)
    );

    bpc_first u_first (
        .aclk            (aclk),
        .adv             (adv),
        .raw_pressure    (s_tdata[RAW_W-1:0]),
        .raw_temperature (s_tdata[2*RAW_W-1:RAW_W]),
        .cal             (cal),
        .d1_out          (f_d1),
        .dev_out         (f_dev),
        .off1_out        (f_off1),
        .sens1_out       (f_sens1),
        .t2_out          (f_t2)
    );

    bpc_cold u_cold (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .d1_in    (f_d1),
        .dev_in   (f_dev),
        .off1_in  (f_off1),
        .sens1_in (f_sens1),
        .t2_in    (f_t2),
        .d1_out   (c_d1),
        .temp_out (c_temp),
        .off_out  (c_off),
        .sens_out (c_sens)
    );

    bpc_press u_press (
        .aclk     (aclk),
        .adv      (adv),
        .d1_in    (c_d1),
        .temp_in  (c_temp),
        .off_in   (c_off),
        .sens_in  (c_sens),
        .temp_out (p_temp),
        .pres_out (p_pres)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg    <= valid_next;
            m_tvalid_reg <= valid_reg[STAGES-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {{(M_TDATA_W-PRES_W-TEMP_W){1'b0}}, p_pres, p_temp};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    stall_holds_valids: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg) && m_tvalid_reg)
        else $error("pipeline valid bits moved during a stall");

    valid_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && valid_reg[STAGES-2] |=> m_tvalid_reg)
        else $error("last stage transaction did not reach the output register");

    reset_empties_pipe: assert property (@(posedge aclk)
        !aresetn |=> valid_reg == '0 && !m_tvalid_reg)
        else $error("reset left a valid transaction in the pipeline");
`endif

endmodule

`default_nettype wire

### bench/tb_baro_pressure_temp_compensation.sv
// Self-checking bench for baro_pressure_temp_compensation: drives raw sample
// pairs and calibration words, predicts each compensated reading, compares.
// Depends on bpc_pkg and the baro_pressure_temp_compensation RTL.
`default_nettype none

module tb_baro_pressure_temp_compensation
    import bpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint PRES_MAX = 64'sd2147483647;
    localparam longint PRES_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic signed [PRES_W-1:0] pressure_centi;
    } reading_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CAL_W-1:0]       cfg_wr_data;

    cal_t     cal_model;
    reading_t pending_readings[$];
    int       mismatches;
    int       quiet_cycles;
    bit       tx_idle_en;
    logic     rx_idle_en;
    logic     hold_request;

    baro_pressure_temp_compensation DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic reading_t compensate_reading(input logic [RAW_W-1:0] d1_raw,
                                                    input logic [RAW_W-1:0] d2_raw,
                                                    input cal_t cal);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, dev, off, sens, sq5, p;
        reading_t r;
        d1 = longint'(d1_raw);
        d2 = longint'(d2_raw);
        c1 = longint'(cal.pressure_sensitivity);
        c2 = longint'(cal.pressure_offset);
        c3 = longint'(cal.sens_temp_coeff);
        c4 = longint'(cal.offset_temp_coeff);
        c5 = longint'(cal.reference_temperature);
        c6 = longint'(cal.temp_sens_coeff);
        dt   = d2 - c5 * 256;
        dev  = (dt * c6) >>> 23;
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        if (dev < 0) begin
            sq5  = 5 * dev * dev;
            dev  = dev - ((dt * dt) >>> 31);
            off  = off - (sq5 >>> 1);
            sens = sens - (sq5 >>> 2);
        end
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (p > PRES_MAX) p = PRES_MAX;
        if (p < PRES_MIN) p = PRES_MIN;
        r.temperature_centi = TEMP_W'(dev + 2000);
        r.pressure_centi    = PRES_W'(p);
        return r;
    endfunction

    function automatic cal_t random_calibration();
        cal_t c;
        logic [CAL_W-1:0] w[6];
        foreach (w[i]) begin
            case ($urandom_range(0, 5))
                0: w[i] = '0;
                1: w[i] = '1;
                default: w[i] = CAL_W'($urandom_range(0, 65535));
            endcase
        end
        c = {w[0], w[1], w[2], w[3], w[4], w[5]};
        return c;
    endfunction

    function automatic logic [RAW_W-1:0] near_reference(input cal_t cal);
        longint v;
        int offset;
        offset = $urandom_range(0, 8192);
        v = longint'(cal.reference_temperature);
        v = v * 256 + offset - 4096;
        if (v < 0) v = 0;
        if (v > 64'sd16777215) v = 64'sd16777215;
        return RAW_W'(v);
    endfunction

    task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d2, d1};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_readings.push_back(compensate_reading(d1, d2, cal_model));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_beat(input logic [CFG_ADDR_W-1:0] addr, input logic [CAL_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic load_calibration(input cal_t cal);
        drain_pipeline();
        cfg_beat(REG_PRESSURE_SENSITIVITY, cal.pressure_sensitivity);
        cfg_beat(REG_PRESSURE_OFFSET, cal.pressure_offset);
        cfg_beat(REG_SENS_TEMP_COEFF, cal.sens_temp_coeff);
        cfg_beat(REG_OFFSET_TEMP_COEFF, cal.offset_temp_coeff);
        cfg_beat(REG_REFERENCE_TEMPERATURE, cal.reference_temperature);
        cfg_beat(REG_TEMP_SENS_COEFF, cal.temp_sens_coeff);
        // writes past the last register must be dropped
        cfg_beat($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CAL_W'($urandom));
        cfg_wr_en <= 1'b0;
        cal_model = cal;
        @(posedge aclk);
    endtask

    task automatic send_random_sample();
        logic [RAW_W-1:0] d1, d2;
        case ($urandom_range(0, 9))
            0: d1 = '0;
            1: d1 = RAW_MAX;
            default: d1 = RAW_W'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) d2 = near_reference(cal_model);
        else d2 = RAW_W'($urandom);
        send_sample(d1, d2);
    endtask

    task automatic test_unset_calibration();
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_W'($urandom), RAW_W'($urandom));
    endtask

    task automatic test_corner_readings();
        cal_t typical;
        logic [RAW_W-1:0] ref_raw;
        typical = '{pressure_sensitivity: 16'd40127, pressure_offset: 16'd36924,
                    sens_temp_coeff: 16'd23317, offset_temp_coeff: 16'd23282,
                    reference_temperature: 16'd33464, temp_sens_coeff: 16'd28312};
        load_calibration(typical);
        ref_raw = {typical.reference_temperature, 8'd0};
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_MAX, '0);
        send_sample('0, RAW_MAX);
        send_sample(24'd9085466, ref_raw);
        send_sample(24'd9085466, ref_raw - 24'd1);
        send_sample(24'd9085466, ref_raw + 24'd1);
        send_sample(24'd9085466, 24'd8569150);
        send_sample(RAW_MAX, ref_raw - 24'd2000000);
        load_calibration('1);
        send_sample('0, '0);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, RAW_MAX);
        send_sample(RAW_MAX, {16'hFFFF, 8'd0} - 24'd1);
    endtask

    task automatic test_random_calibrations();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_calibration('0);
                1: load_calibration('1);
                default: load_calibration(random_calibration());
            endcase
            tx_idle_en = (phase != 3);
            rx_idle_en <= (phase != 4);
            repeat (90) send_random_sample();
        end
    endtask

    task automatic test_output_backpressure();
        load_calibration(random_calibration());
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        hold_request <= 1'b1;
        repeat (60) send_random_sample();
    endtask

    task automatic test_full_rate();
        load_calibration(random_calibration());
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        repeat (100) send_random_sample();
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request <= 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        reading_t want;
        logic signed [TEMP_W-1:0] got_temp;
        logic signed [PRES_W-1:0] got_pres;
        if (aresetn && m_tvalid && m_tready) begin
            got_temp = m_tdata[TEMP_W-1:0];
            got_pres = m_tdata[TEMP_W +: PRES_W];
            if (pending_readings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got temperature %0d pressure %0d",
                         $time, got_temp, got_pres);
            end else begin
                want = pending_readings.pop_front();
                if (got_temp !== want.temperature_centi) begin
                    mismatches++;
                    $display("%0t: temperature_centi expected %0d, got %0d",
                             $time, want.temperature_centi, got_temp);
                end
                if (got_pres !== want.pressure_centi) begin
                    mismatches++;
                    $display("%0t: pressure_centi expected %0d, got %0d",
                             $time, want.pressure_centi, got_pres);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[baro_pressure_temp_compensation] ERROR");
                $finish;
            end
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_addr     <= '0;
        cfg_wr_data  <= '0;
        rx_idle_en   <= 1'b1;
        hold_request <= 1'b0;
        quiet_cycles <= 0;
        tx_idle_en   = 1'b1;
        mismatches   = 0;
        cal_model    = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unset_calibration();
        test_corner_readings();
        test_random_calibrations();
        test_output_backpressure();
        test_full_rate();

        drain_pipeline();
        repeat (2 * STAGES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[baro_pressure_temp_compensation] OK");
        end else begin
            $display("[baro_pressure_temp_compensation] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
